[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the calendar time difference block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on the rising clock edge and disabled during reset.
`define CTD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("calendar time difference: property violated");

// Condition that must never be seen while out of reset.
`define CTD_ASSERT_NEVER(label, clk, rst_n, expr) \
  `CTD_ASSERT(label, clk, rst_n, !(expr))

`endif

[rtl/core/ctd_pkg.sv]
// Types, constants and calendar tables of the calendar time difference block.
`timescale 1ns / 1ps

package ctd_pkg;

  // Result unit codes held in the unit register; code 3 behaves as seconds.
  typedef enum logic [1:0] {
    UNIT_DAYS    = 2'd0,
    UNIT_MINUTES = 2'd1,
    UNIT_SECONDS = 2'd2
  } unit_mode_e;

  localparam logic [1:0]  UNIT_MODE_RESET = 2'd2;
  localparam logic        REG_UNIT_MODE   = 1'b0;

  // Year bias keeps the March-based year positive; reciprocal of 100 for year division.
  localparam logic [14:0] YEAR_BIAS     = 15'd400;
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int unsigned RECIP_SHIFT   = 19;
  localparam logic [23:0] DAYS_PER_YEAR = 24'd365;

  localparam logic signed [18:0] SEC_PER_MIN  = 19'sd60;
  localparam logic signed [18:0] SEC_PER_HOUR = 19'sd3600;
  localparam logic signed [18:0] MIN_PER_HOUR = 19'sd60;
  localparam logic [5:0]         ROUND_SECOND = 6'd30;

  localparam logic signed [17:0] SCALE_DAY = 18'sd1;
  localparam logic signed [17:0] SCALE_MIN = 18'sd1440;
  localparam logic signed [17:0] SCALE_SEC = 18'sd86400;

  // One date after the first pass: March-based year, its hundreds, day of year, validity.
  typedef struct packed {
    logic [14:0] yy;
    logic [8:0]  q100;
    logic [8:0]  doy;
    logic        ok;
  } date_prep_t;

  // Days from 1 March to the first of the given month.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                     r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:       r = 5'd31;
      default:                  r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/calendar_time_difference_core.sv]
// Top level of the calendar time difference block: five-register datapath and APB register.
`timescale 1ns / 1ps

// Calendar time difference core. Each accepted word carries two Gregorian timestamps and
// produces exactly one result word: the signed difference, second timestamp minus first,
// in days, in minutes (each minute raised by one when its seconds are 30 or more) or in
// seconds, as chosen by the unit register at byte address 0 (reset value: seconds; code 3
// also gives seconds). If either date does not exist (month 0 or above 12, day 0, or a day
// past the end of its month) invalid_o is raised and the difference is zero. Out-of-range
// time fields are not checked and enter the arithmetic at face value. busy is never
// raised, so a new word is taken on every clock cycle and the throughput is one word per
// cycle. The result appears on done_o once the word has passed an input register, a date
// preparation register (year hundreds, validity and day of year), a day number register,
// a day difference register and the result register, with no more than two constant
// multiplications in series between two of them. The receiver cannot stall the block:
// each result is shown for a single cycle and must be taken then. The unit register may
// only be written while no word is in flight.
module calendar_time_difference_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command channel
  input  logic                start,
  output logic                busy,
  input  logic [5:0]          first_second_i,
  input  logic [5:0]          first_minute_i,
  input  logic [4:0]          first_hour_i,
  input  logic [4:0]          first_day_i,
  input  logic [3:0]          first_month_i,
  input  logic [13:0]         first_year_i,
  input  logic [5:0]          second_second_i,
  input  logic [5:0]          second_minute_i,
  input  logic [4:0]          second_hour_i,
  input  logic [4:0]          second_day_i,
  input  logic [3:0]          second_month_i,
  input  logic [13:0]         second_year_i,
  // Result channel
  output logic                done_o,
  output logic signed [39:0]  difference_o,
  output logic                invalid_o,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ctd_pkg::*;

  // The datapath takes a word on every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Configuration register. Only the word address bit is decoded; the low address bits
  // select bytes and are ignored.
  // ---------------------------------------------------------------------------------------
  logic [1:0] unit_mode_q, unit_mode_d;
  logic       reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    unit_mode_d = unit_mode_q;
    if (reg_write && (paddr[2] == REG_UNIT_MODE)) begin
      unit_mode_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_mode_q <= UNIT_MODE_RESET;
    end else begin
      unit_mode_q <= unit_mode_d;
    end
  end

  assign prdata = (paddr[2] == REG_UNIT_MODE) ? {30'd0, unit_mode_q} : 32'd0;

  // ---------------------------------------------------------------------------------------
  // Date preparation. The year is taken from March, so that the leap day falls at the end
  // of the year; division of the year by 100 is a multiplication by a scaled reciprocal,
  // which is exact over the whole 15-bit range.
  // ---------------------------------------------------------------------------------------
  function automatic date_prep_t prep_date(input logic [4:0] d, input logic [3:0] m,
                                           input logic [13:0] y);
    logic        before_march;
    logic [27:0] yy_prod;
    logic [26:0] y_prod;
    logic [7:0]  y_q;
    logic [13:0] y_rem;
    logic        leap;
    date_prep_t  r;
    before_march = (m == 4'd1) || (m == 4'd2);
    r.yy         = {1'b0, y} + YEAR_BIAS - {14'd0, before_march};
    yy_prod      = {13'd0, r.yy} * {15'd0, RECIP_100};
    r.q100       = yy_prod[RECIP_SHIFT +: 9];
    y_prod       = {13'd0, y} * {14'd0, RECIP_100};
    y_q          = y_prod[RECIP_SHIFT +: 8];
    y_rem        = y - 14'({6'd0, y_q} * 14'd100);
    leap         = (y[1:0] == 2'd0) && ((y_rem != 14'd0) || (y_q[1:0] == 2'd0));
    r.ok         = (m >= 4'd1) && (m <= 4'd12) && (d != 5'd0) && (d <= month_length(m, leap));
    r.doy        = month_offset(m) + {4'd0, d} - 9'd1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------------------------
  logic        v0_q;
  logic [5:0]  s1_q, n1_q, s2_q, n2_q;
  logic [4:0]  h1_q, d1_q, h2_q, d2_q;
  logic [3:0]  m1_q, m2_q;
  logic [13:0] y1_q, y2_q;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_q <= first_second_i;
      n1_q <= first_minute_i;
      h1_q <= first_hour_i;
      d1_q <= first_day_i;
      m1_q <= first_month_i;
      y1_q <= first_year_i;
      s2_q <= second_second_i;
      n2_q <= second_minute_i;
      h2_q <= second_hour_i;
      d2_q <= second_day_i;
      m2_q <= second_month_i;
      y2_q <= second_year_i;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: both dates prepared; the time fields travel on unchanged.
  // ---------------------------------------------------------------------------------------
  logic        v1_q;
  date_prep_t  p1_q, p2_q, p1_d, p2_d;
  logic [5:0]  ts1_q, tn1_q, ts2_q, tn2_q;
  logic [4:0]  th1_q, th2_q;

  assign p1_d = prep_date(d1_q, m1_q, y1_q);
  assign p2_d = prep_date(d2_q, m2_q, y2_q);

  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    ts1_q <= s1_q;
    tn1_q <= n1_q;
    th1_q <= h1_q;
    ts2_q <= s2_q;
    tn2_q <= n2_q;
    th2_q <= h2_q;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: day numbers of both dates, and the time-of-day part of the result in the
  // selected unit.
  // ---------------------------------------------------------------------------------------
  logic        v2_q;
  logic [23:0] dn1_q, dn2_q, dn1_d, dn2_d;
  logic        ok2_q;
  logic signed [18:0] time2_q, time2_d;
  logic signed [7:0]  sec_delta, min_delta, rmin_delta;
  logic signed [6:0]  hour_delta;
  logic [6:0]         rmin1, rmin2;

  assign dn1_d = {9'd0, p1_q.yy} * DAYS_PER_YEAR + {11'd0, p1_q.yy[14:2]}
               - {15'd0, p1_q.q100} + {17'd0, p1_q.q100[8:2]} + {15'd0, p1_q.doy};
  assign dn2_d = {9'd0, p2_q.yy} * DAYS_PER_YEAR + {11'd0, p2_q.yy[14:2]}
               - {15'd0, p2_q.q100} + {17'd0, p2_q.q100[8:2]} + {15'd0, p2_q.doy};

  // Minutes are rounded up from half a minute of seconds.
  assign rmin1 = {1'b0, tn1_q} + {6'd0, (ts1_q >= ROUND_SECOND)};
  assign rmin2 = {1'b0, tn2_q} + {6'd0, (ts2_q >= ROUND_SECOND)};

  assign sec_delta  = $signed({2'b00, ts2_q}) - $signed({2'b00, ts1_q});
  assign min_delta  = $signed({2'b00, tn2_q}) - $signed({2'b00, tn1_q});
  assign rmin_delta = $signed({1'b0, rmin2}) - $signed({1'b0, rmin1});
  assign hour_delta = $signed({2'b00, th2_q}) - $signed({2'b00, th1_q});

  always_comb begin
    case (unit_mode_q)
      UNIT_DAYS: begin
        time2_d = 19'sd0;
      end
      UNIT_MINUTES: begin
        time2_d = 19'(rmin_delta) + 19'(hour_delta) * MIN_PER_HOUR;
      end
      default: begin
        time2_d = 19'(sec_delta) + 19'(min_delta) * SEC_PER_MIN
                + 19'(hour_delta) * SEC_PER_HOUR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    dn1_q   <= dn1_d;
    dn2_q   <= dn2_d;
    ok2_q   <= p1_q.ok && p2_q.ok;
    time2_q <= time2_d;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: difference of the day numbers.
  // ---------------------------------------------------------------------------------------
  logic               v3_q;
  logic signed [23:0] days_q;
  logic               ok3_q;
  logic signed [18:0] time3_q;

  always_ff @(posedge clk_i) begin
    days_q  <= $signed(dn2_q - dn1_q);
    ok3_q   <= ok2_q;
    time3_q <= time2_q;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: days scaled to the selected unit, time part added, result registered.
  // ---------------------------------------------------------------------------------------
  logic signed [17:0] scale;
  logic signed [41:0] scaled_days, total;
  logic signed [39:0] difference_d;

  always_comb begin
    case (unit_mode_q)
      UNIT_DAYS:    scale = SCALE_DAY;
      UNIT_MINUTES: scale = SCALE_MIN;
      default:      scale = SCALE_SEC;
    endcase
  end

  assign scaled_days  = days_q * scale;
  assign total        = scaled_days + 42'(time3_q);
  assign difference_d = ok3_q ? total[39:0] : 40'sd0;

  logic done_q;
  logic signed [39:0] difference_q;
  logic invalid_q;

  always_ff @(posedge clk_i) begin
    difference_q <= difference_d;
    invalid_q    <= !ok3_q;
  end

  // Word-valid flags along the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start && !busy;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  assign done_o       = done_q;
  assign difference_o = difference_q;
  assign invalid_o    = done_q && invalid_q;

endmodule

[rtl/core/ctd_checker.sv]
// Port-level checker of the calendar time difference core, attached by bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [3:0]         first_month_i,
  input logic [3:0]         second_month_i,
  input logic               done_o,
  input logic signed [39:0] difference_o,
  input logic               invalid_o
);

  logic accepted;
  logic bad_month;

  assign accepted  = start && !busy;
  assign bad_month = (first_month_i == 4'd0) || (first_month_i > 4'd12)
                  || (second_month_i == 4'd0) || (second_month_i > 4'd12);

  // The core never refuses a word.
  `CTD_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)
  // Every accepted word gives its result, and a result is only given for an accepted word.
  `CTD_ASSERT(a_result_follows, clk_i, rst_ni, accepted |-> ##5 done_o)
  `CTD_ASSERT(a_result_has_word, clk_i, rst_ni, done_o |-> $past(accepted, 5))
  // A month outside the calendar always gives an invalid result.
  `CTD_ASSERT(a_bad_month_flagged, clk_i, rst_ni, (accepted && bad_month) |-> ##5 invalid_o)
  // An invalid result carries a zero difference.
  `CTD_ASSERT(a_invalid_zero, clk_i, rst_ni, (done_o && invalid_o) |-> (difference_o == 40'sd0))

endmodule

bind calendar_time_difference_core ctd_checker u_ctd_checker (.*);
